// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on every rising edge outside reset.
`define GVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define GVN_ASSERT_IMPL(lbl, ante, cons, msg) \
  `GVN_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/gvn_pkg.sv
// ---------------------------------------------------------------------------
// gvn_pkg
// Widths, register indexes and the queue entry format of the grid vertex
// normal generator.
// ---------------------------------------------------------------------------
`default_nettype none

package gvn_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned FifoDepthDef = 4;

  // Column fields can index up to 4096 columns (12 bits).
  localparam int unsigned ColW      = 12;
  localparam int unsigned RowW      = 16;
  localparam int unsigned PosW      = 32;
  localparam int unsigned NrmW      = 16;
  localparam int unsigned VtxColW   = 8;
  localparam int unsigned WidthRegW = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegWidthInUse  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeightInUse = 2'd1;

  localparam logic [WidthRegW-1:0] WidthReset  = 9'd256;
  localparam logic [RowW-1:0]      HeightReset = 16'd2;

  typedef logic [1:0] slot_t;

  // One normal to be computed: the vertex and where its neighbours live.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    slot_t           slot_self;
    slot_t           slot_up;
    slot_t           slot_dn;
    logic            has_lt;
    logic            has_rt;
    logic            has_up;
    logic            has_dn;
    logic            last;
  } job_t;

  // Queue entry: an optional store write followed by an optional job.
  typedef struct packed {
    logic                   wr;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    slot_t                  wr_slot;
    logic [ColW-1:0]        wr_col;
    logic                   job_vld;
    job_t                   job;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/gvn_if.sv
// ---------------------------------------------------------------------------
// gvn interfaces
// Valid/ready channels for positions, normals and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface gvn_pos_if import gvn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gvn_nrm_if import gvn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [NrmW-1:0] normal_x;
  logic signed [NrmW-1:0] normal_y;
  logic signed [NrmW-1:0] normal_z;
  logic [VtxColW-1:0]     vertex_col;
  logic [RowW-1:0]        vertex_row;
  logic                   degenerate;
  logic                   last;
  modport source (output valid, normal_x, normal_y, normal_z, vertex_col, vertex_row,
                  degenerate, last, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, vertex_col, vertex_row,
                degenerate, last, output ready);
endinterface

interface gvn_cfg_if import gvn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/grid_vertex_normal_generator.sv
// ---------------------------------------------------------------------------
// grid_vertex_normal_generator
// Per-vertex unit normals of a raster-ordered grid mesh by central
// differences, Q16.16 positions in and Q1.14 normals out.
// ---------------------------------------------------------------------------
//
//   port    direction  carries
//   ------  ---------  --------------------------------------------------
//   cfg_i   in         register writes: index 0 row width, 1 row count
//   pos_i   in         one vertex position per transfer, raster order
//   nrm_o   out        one normal per transfer, with its column and row
//
// Each normal passes through the shared compute engine of the back end: five
// store reads, six multiplies for the cross product and three squarings, the
// 32-step square root and three 15-step divisions; a degenerate normal goes
// from the cross product straight to the output. The front takes a vertex and
// then pushes its queue entries (one for a first-row vertex, one to three for
// later vertices), stalling while the queue is full, before it is ready again.
// Reset clears the counters and queue; the row store is not cleared and holds
// no valid data until written. The front accepts a vertex while the back is
// still busy, as long as the queue has room, and the output register lets the
// back start its next normal while a finished one waits for the sink.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grid_vertex_normal_generator import gvn_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gvn_cfg_if.sink     cfg_i,
  gvn_pos_if.sink     pos_i,
  gvn_nrm_if.source   nrm_o
);

  // Entries passing from the front to the back.
  entry_t push_entry, pop_entry;
  logic   push, pop, fifo_full, fifo_empty;

  // Conditions watched by the checks at the end.
  logic   nrm_is_zero, nrm_deg_vld, nrm_plain_vld;

  // The front tracks the raster position and decides which normals become
  // computable with each vertex.
  gvn_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pos_i   (pos_i),
    .cfg_i   (cfg_i),
    .entry_o (push_entry),
    .push_o  (push),
    .full_i  (fifo_full)
  );

  gvn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (fifo_empty)
  );

  // The back owns the row store, so a write and the reads that depend on it
  // stay in queue order.
  gvn_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_entry),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .nrm_o   (nrm_o)
  );

  assign nrm_is_zero   = (nrm_o.normal_x == '0) && (nrm_o.normal_y == '0) &&
                         (nrm_o.normal_z == '0);
  assign nrm_deg_vld   = nrm_o.valid && nrm_o.degenerate;
  assign nrm_plain_vld = nrm_o.valid && !nrm_o.degenerate;

  `GVN_ASSERT_IMPL(a_queue_no_overflow, push, !fifo_full, "queue written while full")
  `GVN_ASSERT_IMPL(a_queue_no_underflow, pop, !fifo_empty, "queue read while empty")
  `GVN_ASSERT_IMPL(a_degenerate_zero, nrm_deg_vld, nrm_is_zero, "degenerate normal not zero")
  `GVN_ASSERT_IMPL(a_normal_nonzero, nrm_plain_vld, !nrm_is_zero, "zero normal not flagged")

endmodule

`default_nettype wire

// File: rtl/gvn_fifo.sv
// ---------------------------------------------------------------------------
// gvn_fifo
// Short queue of entries between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module gvn_fifo import gvn_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = store_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= inc_ptr(wr_ptr_q);
      if (pop_i) rd_ptr_q <= inc_ptr(rd_ptr_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// File: rtl/gvn_front.sv
// ---------------------------------------------------------------------------
// gvn_front
// Takes positions, tracks the raster position and splits each vertex into
// a store write and the normals it makes computable.
// ---------------------------------------------------------------------------
`default_nettype none

module gvn_front import gvn_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gvn_pos_if.sink   pos_i,
  gvn_cfg_if.sink   cfg_i,
  output entry_t    entry_o,
  output logic      push_o,
  input  logic      full_i
);

  localparam int unsigned LimW = ColW + 1;
  localparam logic [LimW-1:0] MaxW = LimW'(MAX_WIDTH);

  logic [WidthRegW-1:0] width_q;
  logic [RowW-1:0]      height_q;
  logic [ColW-1:0]      col_q;
  logic [RowW-1:0]      row_q;
  slot_t                slot_q;
  logic                 busy_q, first_q;
  logic [2:0]           pend_q;

  job_t                 job_q [3];
  logic signed [PosW-1:0] px_q, py_q, pz_q;
  slot_t                wslot_q;
  logic [ColW-1:0]      wcol_q;

  logic [LimW-1:0] w_raw, w_eff;
  logic [RowW-1:0] h_eff;
  logic            last_col, last_row, accept;
  slot_t           slot_prev, slot_next;
  logic            c_pos, c_gt1, r_pos, r_gt1;
  job_t            job_d [3];
  logic [2:0]      mask_d, rest;
  logic [1:0]      sel;

  function automatic job_t make_job(input logic [ColW-1:0] c, input logic [RowW-1:0] r,
                                    input slot_t ss, input slot_t su, input slot_t sd,
                                    input logic lt, input logic rt, input logic up,
                                    input logic dn);
    job_t j;
    j.col = c; j.row = r;
    j.slot_self = ss; j.slot_up = su; j.slot_dn = sd;
    j.has_lt = lt; j.has_rt = rt; j.has_up = up; j.has_dn = dn;
    j.last = 1'b0;
    return j;
  endfunction

  assign pos_i.ready = !busy_q;
  assign cfg_i.ready = 1'b1;
  assign accept      = pos_i.valid && !busy_q;

  always_comb begin
    w_raw = LimW'(width_q);
    if (w_raw > MaxW) w_eff = MaxW;
    else if (w_raw < LimW'(2)) w_eff = LimW'(2);
    else w_eff = w_raw;
    h_eff     = (height_q < 16'd2) ? 16'd2 : height_q;
    last_col  = LimW'(col_q) >= (w_eff - 1'b1);
    last_row  = row_q >= (h_eff - 16'd1);
    slot_prev = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
    slot_next = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
    c_pos = (col_q != '0);
    c_gt1 = (col_q > ColW'(1));
    r_pos = (row_q != '0);
    r_gt1 = (row_q > 16'd1);
    // Vertex above, once its lower neighbour has arrived.
    job_d[0] = make_job(col_q, row_q - 16'd1, slot_prev, slot_next, slot_q,
                        c_pos, !last_col, r_gt1, 1'b1);
    // Last row: the vertex to the left now has its right neighbour.
    job_d[1] = make_job(col_q - 1'b1, row_q, slot_q, slot_prev, slot_q,
                        c_gt1, 1'b1, r_pos, 1'b0);
    // Last row, last column: the vertex itself.
    job_d[2] = make_job(col_q, row_q, slot_q, slot_prev, slot_q,
                        c_pos, 1'b0, r_pos, 1'b0);
    mask_d = {last_row && last_col, last_row && c_pos, r_pos};
  end

  always_comb begin
    if (pend_q[0]) sel = 2'd0;
    else if (pend_q[1]) sel = 2'd1;
    else sel = 2'd2;
    rest = pend_q & ~(3'b001 << sel);
    entry_o.wr       = first_q;
    entry_o.pos_x    = px_q;
    entry_o.pos_y    = py_q;
    entry_o.pos_z    = pz_q;
    entry_o.wr_slot  = wslot_q;
    entry_o.wr_col   = wcol_q;
    entry_o.job_vld  = |pend_q;
    entry_o.job      = job_q[sel];
    entry_o.job.last = (rest == '0);
  end

  assign push_o = busy_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      busy_q   <= 1'b0;
      first_q  <= 1'b0;
      pend_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          RegWidthInUse:  width_q  <= cfg_i.data[WidthRegW-1:0];
          RegHeightInUse: height_q <= cfg_i.data[RowW-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        first_q <= 1'b0;
        pend_q  <= rest;
        if (rest == '0) busy_q <= 1'b0;
      end
      if (accept) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        pend_q  <= mask_d;
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + 16'd1;
            slot_q <= slot_next;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q   <= job_d;
      px_q    <= pos_i.pos_x;
      py_q    <= pos_i.pos_y;
      pz_q    <= pos_i.pos_z;
      wslot_q <= slot_q;
      wcol_q  <= col_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gvn_back.sv
// ---------------------------------------------------------------------------
// gvn_back
// Holds the three-row store and computes one normal at a time with a
// shared multiplier, an iterative square root and an iterative divider.
// ---------------------------------------------------------------------------
`default_nettype none

module gvn_back import gvn_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      entry_i,
  input  logic        empty_i,
  output logic        pop_o,
  gvn_nrm_if.source   nrm_o
);

  localparam int unsigned Depth = 3 * MAX_WIDTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned NumW  = 47;
  localparam int unsigned QW    = 15;

  localparam logic [2:0] NbSelf  = 3'd0;
  localparam logic [2:0] NbLeft  = 3'd1;
  localparam logic [2:0] NbRight = 3'd2;
  localparam logic [2:0] NbUp    = 3'd3;
  localparam logic [2:0] NbDown  = 3'd4;

  typedef enum logic [3:0] {
    SIdle, SRead, SDiff, SScale, SMul, SMag, SNorm, SSq, SSqrt, SDivInit, SDiv, SOut
  } state_e;

  state_e      state_q;
  logic [5:0]  cnt_q;
  logic [1:0]  comp_q;
  logic        deg_q;
  logic        out_vld_q;

  logic [3*PosW-1:0] mem [Depth];
  logic [3*PosW-1:0] rdata_q;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic              mem_we;

  job_t                    job_q;
  logic signed [PosW-1:0]  p_q [5][3];
  logic signed [32:0]      d_q [6];
  logic signed [30:0]      s_q [6];
  logic signed [30:0]      mul_a, mul_b;
  logic signed [61:0]      prod_q;
  logic signed [63:0]      cr_q [3];
  logic [61:0]             mg_q [3];
  logic [61:0]             m_q;
  logic [2:0]              neg_q;
  logic [63:0]             x_q, res_q, bit_q;
  logic [NumW-1:0]         num_q;
  logic [QW-1:0]           q_q;
  logic signed [NrmW-1:0]  nrm_q [3];

  logic signed [30:0] sc [6];
  logic [61:0]        cr_mag [3];
  logic [61:0]        cr_max;
  logic [63:0]        trial;
  logic               sq_take;
  logic [NumW-1:0]    den_sh;
  logic               div_take;
  logic [QW-1:0]      q_next;
  logic               norm_r4, norm_r1, norm_l4, norm_l1, cr_zero;
  logic [2:0]         rd_idx;

  function automatic logic [AddrW-1:0] mk_addr(input slot_t s, input logic [ColW-1:0] c);
    logic [AddrW+1:0] a;
    a = (AddrW+2)'(s) * (AddrW+2)'(MAX_WIDTH) + (AddrW+2)'(c);
    return a[AddrW-1:0];
  endfunction

  assign pop_o   = (state_q == SIdle) && !empty_i;
  assign mem_we  = pop_o && entry_i.wr;
  assign wr_addr = mk_addr(entry_i.wr_slot, entry_i.wr_col);
  assign rd_idx  = cnt_q[2:0] - 3'd1;

  always_comb begin
    rd_addr = mk_addr(job_q.slot_self, job_q.col);
    case (cnt_q[2:0])
      NbSelf:  ;
      NbLeft:  if (job_q.has_lt) rd_addr = mk_addr(job_q.slot_self, job_q.col - 1'b1);
      NbRight: if (job_q.has_rt) rd_addr = mk_addr(job_q.slot_self, job_q.col + 1'b1);
      NbUp:    if (job_q.has_up) rd_addr = mk_addr(job_q.slot_up, job_q.col);
      NbDown:  if (job_q.has_dn) rd_addr = mk_addr(job_q.slot_dn, job_q.col);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= {entry_i.pos_x, entry_i.pos_y, entry_i.pos_z};
    rdata_q <= mem[rd_addr];
  end

  // Common right shift that brings all six differences into 31 bits.
  always_comb begin
    logic [32:0] mag;
    logic [1:0]  sh;
    sh = 2'd0;
    for (int i = 0; i < 6; i++) begin
      mag = d_q[i][32] ? 33'(-d_q[i]) : 33'(d_q[i]);
      if (mag[31]) sh = 2'd2;
      else if (mag[30] && sh == 2'd0) sh = 2'd1;
    end
    for (int i = 0; i < 6; i++) begin
      sc[i] = 31'(d_q[i] >>> sh);
    end
  end

  // Magnitudes of the cross product and the largest of them.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_mag[i] = cr_q[i][63] ? 62'(-cr_q[i]) : 62'(cr_q[i]);
    end
    cr_max = cr_mag[0];
    if (cr_mag[1] > cr_max) cr_max = cr_mag[1];
    if (cr_mag[2] > cr_max) cr_max = cr_mag[2];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == SMul) begin
      case (cnt_q[2:0])
        3'd0:    begin mul_a = s_q[1]; mul_b = s_q[5]; end
        3'd1:    begin mul_a = s_q[2]; mul_b = s_q[4]; end
        3'd2:    begin mul_a = s_q[2]; mul_b = s_q[3]; end
        3'd3:    begin mul_a = s_q[0]; mul_b = s_q[5]; end
        3'd4:    begin mul_a = s_q[0]; mul_b = s_q[4]; end
        3'd5:    begin mul_a = s_q[1]; mul_b = s_q[3]; end
        default: ;
      endcase
    end else begin
      case (cnt_q[1:0])
        2'd0:    begin mul_a = $signed({1'b0, mg_q[0][29:0]}); end
        2'd1:    begin mul_a = $signed({1'b0, mg_q[1][29:0]}); end
        2'd2:    begin mul_a = $signed({1'b0, mg_q[2][29:0]}); end
        default: ;
      endcase
      mul_b = mul_a;
    end
  end

  always_comb begin
    norm_r4  = m_q[61:34] != '0;
    norm_r1  = m_q[61:30] != '0;
    norm_l4  = m_q[61:25] == '0;
    norm_l1  = m_q[61:29] == '0;
    cr_zero  = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
    trial    = res_q + bit_q;
    sq_take  = x_q >= trial;
    den_sh   = NumW'({res_q[31:0], 1'b0}) << cnt_q[3:0];
    div_take = num_q >= den_sh;
    q_next   = q_q | (div_take ? (QW'(1) << cnt_q[3:0]) : '0);
  end

  assign nrm_o.valid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= SIdle;
      cnt_q            <= '0;
      comp_q           <= '0;
      deg_q            <= 1'b0;
      out_vld_q        <= 1'b0;
      nrm_o.normal_x   <= '0;
      nrm_o.normal_y   <= '0;
      nrm_o.normal_z   <= '0;
      nrm_o.vertex_col <= '0;
      nrm_o.vertex_row <= '0;
      nrm_o.degenerate <= 1'b0;
      nrm_o.last       <= 1'b0;
    end else begin
      if (out_vld_q && nrm_o.ready && (state_q != SOut)) out_vld_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (pop_o && entry_i.job_vld) begin
            state_q <= SRead;
            cnt_q   <= '0;
          end
        end
        SRead: begin
          if (cnt_q == 6'd5) state_q <= SDiff;
          else cnt_q <= cnt_q + 6'd1;
        end
        SDiff:  state_q <= SScale;
        SScale: begin
          state_q <= SMul;
          cnt_q   <= '0;
        end
        SMul: begin
          if (cnt_q == 6'd6) state_q <= SMag;
          else cnt_q <= cnt_q + 6'd1;
        end
        SMag: begin
          deg_q   <= cr_zero;
          state_q <= cr_zero ? SOut : SNorm;
        end
        SNorm: begin
          if (!norm_r1 && !norm_l1) begin
            state_q <= SSq;
            cnt_q   <= '0;
          end
        end
        SSq: begin
          if (cnt_q == 6'd3) begin
            state_q <= SSqrt;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        SSqrt: begin
          if (cnt_q == 6'd31) begin
            state_q <= SDivInit;
            comp_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        SDivInit: begin
          state_q <= SDiv;
          cnt_q   <= 6'(QW - 1);
        end
        SDiv: begin
          if (cnt_q == '0) begin
            if (comp_q == 2'd2) state_q <= SOut;
            else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= SDivInit;
            end
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        SOut: begin
          if (!out_vld_q || nrm_o.ready) begin
            out_vld_q        <= 1'b1;
            nrm_o.normal_x   <= deg_q ? '0 : nrm_q[0];
            nrm_o.normal_y   <= deg_q ? '0 : nrm_q[1];
            nrm_o.normal_z   <= deg_q ? '0 : nrm_q[2];
            nrm_o.vertex_col <= job_q.col[VtxColW-1:0];
            nrm_o.vertex_row <= job_q.row;
            nrm_o.degenerate <= deg_q;
            nrm_o.last       <= job_q.last;
            state_q          <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: if (pop_o) job_q <= entry_i.job;
      SRead: begin
        if (cnt_q != '0) begin
          p_q[rd_idx][0] <= rdata_q[3*PosW-1:2*PosW];
          p_q[rd_idx][1] <= rdata_q[2*PosW-1:PosW];
          p_q[rd_idx][2] <= rdata_q[PosW-1:0];
        end
      end
      SDiff: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i]   <= 33'(p_q[NbRight][i]) - 33'(p_q[NbLeft][i]);
          d_q[i+3] <= 33'(p_q[NbUp][i]) - 33'(p_q[NbDown][i]);
        end
      end
      SScale: s_q <= sc;
      SMul: begin
        if (cnt_q != 6'd6) prod_q <= mul_a * mul_b;
        case (cnt_q[2:0])
          3'd1:    cr_q[0] <= 64'(prod_q);
          3'd2:    cr_q[0] <= cr_q[0] - 64'(prod_q);
          3'd3:    cr_q[1] <= 64'(prod_q);
          3'd4:    cr_q[1] <= cr_q[1] - 64'(prod_q);
          3'd5:    cr_q[2] <= 64'(prod_q);
          3'd6:    cr_q[2] <= cr_q[2] - 64'(prod_q);
          default: ;
        endcase
      end
      SMag: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= cr_q[i][63];
          mg_q[i]  <= cr_mag[i];
        end
        m_q <= cr_max;
      end
      SNorm: begin
        // Right shifts truncate; four bits at a time while far out of range.
        if (norm_r4) begin
          m_q <= m_q >> 4;
          for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 4;
        end else if (norm_r1) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 1;
        end else if (norm_l4) begin
          m_q <= m_q << 4;
          for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 4;
        end else if (norm_l1) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 1;
        end
      end
      SSq: begin
        if (cnt_q != 6'd3) prod_q <= mul_a * mul_b;
        if (cnt_q == 6'd1) x_q <= 64'(unsigned'(prod_q));
        else if (cnt_q != '0) x_q <= x_q + 64'(unsigned'(prod_q));
        if (cnt_q == 6'd3) begin
          res_q <= '0;
          bit_q <= 64'd1 << 62;
        end
      end
      SSqrt: begin
        if (sq_take) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      SDivInit: begin
        num_q <= {mg_q[comp_q][31:0], 15'd0} + NumW'(res_q[31:0]);
        q_q   <= '0;
      end
      SDiv: begin
        if (div_take) num_q <= num_q - den_sh;
        q_q <= q_next;
        if (cnt_q == '0) begin
          nrm_q[comp_q] <= neg_q[comp_q] ? NrmW'(-$signed({1'b0, q_next}))
                                         : NrmW'({1'b0, q_next});
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
